@@ sv/triangle_face_normal_core_assert.svh @@
// assertion macros used by the checker file of the face normal core
`ifndef TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TFN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tfn_pkg.sv @@
// types, widths and helpers of the face normal core
`default_nettype none

package tfn_pkg;

    localparam int POS_W      = 32;
    localparam int EDGE_W     = POS_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MANT_W     = 24;
    localparam int SQ_W       = 2 * MANT_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int REM_W      = SUM_W + 1;
    localparam int NORM_W     = 16;
    localparam int Q_W        = 2 * NORM_W;
    localparam int PP_W       = MANT_W + Q_W;
    localparam int N_W        = SQ_W + Q_W;
    localparam int ROOT_W     = NORM_W;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int SQRT_STEPS = Q_W / 2;
    localparam int BACK_LAT   = 3 + DIV_STEPS + SQRT_STEPS + 1;
    localparam int MIDQ_DEPTH = 4;
    localparam int MIDQ_PTR_W = 2;
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = 1;

    localparam int unsigned SCALE_I = (1 << (NORM_W - 1)) - 1;
    localparam logic [NORM_W-1:0] NORM_SCALE = NORM_W'(SCALE_I);
    // (2 * scale)^2, the numerator factor of the squared rounding bound
    localparam logic [Q_W-1:0] NORM_C = Q_W'(64'(SCALE_I) * 64'(SCALE_I) * 64'd4);

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic [CROSS_W-1:0]        mag_t;
    typedef mag_t [2:0]                mag_vec_t;
    typedef logic [MANT_W-1:0]         mant_t;

    typedef struct packed {
        logic [2:0]  neg;
        logic        degen;
        mant_t [2:0] m;
    } front_item_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       degen;
    } side_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     degen;
    } result_t;

    // shift all three magnitudes by w while the largest still needs it
    function automatic mag_vec_t norm_step(mag_vec_t mg, int unsigned w);
        mag_t     orv;
        mag_vec_t r;
        orv = mg[0] | mg[1] | mg[2];
        r   = mg;
        if ((orv >> (MANT_W - 1 + w)) != '0) begin
            for (int i = 0; i < 3; i++) begin
                r[i] = mg[i] >> w;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/tfn_front.sv @@
// front pipeline: edges, cross product, magnitudes and block scaling
`default_nettype none

module tfn_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire tfn_pkg::pos_t        a_x,
    input  wire tfn_pkg::pos_t        a_y,
    input  wire tfn_pkg::pos_t        a_z,
    input  wire tfn_pkg::pos_t        b_x,
    input  wire tfn_pkg::pos_t        b_y,
    input  wire tfn_pkg::pos_t        b_z,
    input  wire tfn_pkg::pos_t        c_x,
    input  wire tfn_pkg::pos_t        c_y,
    input  wire tfn_pkg::pos_t        c_z,
    output tfn_pkg::front_item_t      item,
    output logic                      item_valid,
    input  wire logic                 item_ready
);

    logic                en;
    logic [6:0]          vld_reg;
    tfn_pkg::edge_t      u_reg [3];
    tfn_pkg::edge_t      v_reg [3];
    tfn_pkg::prod_t      p_reg [6];
    tfn_pkg::cross_t     n_reg [3];
    tfn_pkg::mag_vec_t   mag4_reg;
    tfn_pkg::mag_vec_t   mag5_reg;
    tfn_pkg::mag_vec_t   mag6_reg;
    tfn_pkg::mag_vec_t   mag7_reg;
    logic [2:0]          neg4_reg;
    logic [2:0]          neg5_reg;
    logic [2:0]          neg6_reg;
    logic [2:0]          neg7_reg;
    logic                degen4_reg;
    logic                degen5_reg;
    logic                degen6_reg;
    logic                degen7_reg;

    // the whole front holds while its last item waits for queue room
    assign en   = !(vld_reg[6] && !item_ready);
    assign full = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0] <= tfn_pkg::edge_t'(b_x) - tfn_pkg::edge_t'(a_x);
            u_reg[1] <= tfn_pkg::edge_t'(b_y) - tfn_pkg::edge_t'(a_y);
            u_reg[2] <= tfn_pkg::edge_t'(b_z) - tfn_pkg::edge_t'(a_z);
            v_reg[0] <= tfn_pkg::edge_t'(c_x) - tfn_pkg::edge_t'(a_x);
            v_reg[1] <= tfn_pkg::edge_t'(c_y) - tfn_pkg::edge_t'(a_y);
            v_reg[2] <= tfn_pkg::edge_t'(c_z) - tfn_pkg::edge_t'(a_z);

            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= u_reg[2] * v_reg[1];
            p_reg[2] <= u_reg[2] * v_reg[0];
            p_reg[3] <= u_reg[0] * v_reg[2];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= u_reg[1] * v_reg[0];

            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= tfn_pkg::cross_t'(p_reg[2*i]) - tfn_pkg::cross_t'(p_reg[2*i+1]);
            end

            for (int i = 0; i < 3; i++)
            begin
                neg4_reg[i] <= n_reg[i][tfn_pkg::CROSS_W-1];
                mag4_reg[i] <= n_reg[i][tfn_pkg::CROSS_W-1] ?
                               tfn_pkg::mag_t'(-n_reg[i]) : tfn_pkg::mag_t'(n_reg[i]);
            end
            degen4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);

            // block scaling, two shift weights per stage
            mag5_reg   <= tfn_pkg::norm_step(tfn_pkg::norm_step(mag4_reg, 32), 16);
            neg5_reg   <= neg4_reg;
            degen5_reg <= degen4_reg;
            mag6_reg   <= tfn_pkg::norm_step(tfn_pkg::norm_step(mag5_reg, 8), 4);
            neg6_reg   <= neg5_reg;
            degen6_reg <= degen5_reg;
            mag7_reg   <= tfn_pkg::norm_step(tfn_pkg::norm_step(mag6_reg, 2), 1);
            neg7_reg   <= neg6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    always_comb
    begin
        item.neg   = neg7_reg;
        item.degen = degen7_reg;
        for (int i = 0; i < 3; i++)
        begin
            item.m[i] = mag7_reg[i][tfn_pkg::MANT_W-1:0];
        end
    end

    assign item_valid = vld_reg[6];

endmodule

`default_nettype wire

@@ sv/tfn_queue.sv @@
// short queue of classified triangles between front and back
`default_nettype none

module tfn_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire tfn_pkg::front_item_t  in_item,
    output logic                       in_ready,
    output logic                       out_valid,
    output tfn_pkg::front_item_t       out_item,
    input  wire logic                  out_pop
);

    tfn_pkg::front_item_t               mem [tfn_pkg::MIDQ_DEPTH];
    logic [tfn_pkg::MIDQ_PTR_W-1:0]     wr_ptr_reg;
    logic [tfn_pkg::MIDQ_PTR_W-1:0]     rd_ptr_reg;
    logic [tfn_pkg::MIDQ_PTR_W:0]       count_reg;
    logic [tfn_pkg::MIDQ_PTR_W:0]       count_next;
    logic                               do_push;
    logic                               do_pop;

    assign in_ready  = count_reg != (tfn_pkg::MIDQ_PTR_W + 1)'(tfn_pkg::MIDQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (tfn_pkg::MIDQ_PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (tfn_pkg::MIDQ_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tfn_pkg::MIDQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tfn_pkg::MIDQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/tfn_lane.sv @@
// one component: pipelined restoring divide, then pipelined integer square root
`default_nettype none

module tfn_lane (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tfn_pkg::N_W-1:0]       n_in,
    input  wire logic [tfn_pkg::SUM_W-1:0]     s_in,
    output logic [tfn_pkg::ROOT_W-1:0]         root
);

    localparam int DS = tfn_pkg::DIV_STEPS;
    localparam int SS = tfn_pkg::SQRT_STEPS;
    localparam int RT_W = tfn_pkg::SQ_REM_W + 2;

    logic [tfn_pkg::REM_W-1:0]    drem_reg [DS-1];
    logic [tfn_pkg::Q_W-1:0]      dx_reg   [DS];
    logic [tfn_pkg::SUM_W-1:0]    ds_reg   [DS-1];
    logic [tfn_pkg::REM_W-1:0]    drem_in  [DS];
    logic [tfn_pkg::Q_W-1:0]      dx_in    [DS];
    logic [tfn_pkg::SUM_W-1:0]    ds_in    [DS];

    logic [tfn_pkg::SQ_REM_W-1:0] srem_reg  [SS-1];
    logic [tfn_pkg::Q_W-1:0]      sx_reg    [SS-1];
    logic [tfn_pkg::ROOT_W-1:0]   sroot_reg [SS];
    logic [tfn_pkg::SQ_REM_W-1:0] srem_in   [SS];
    logic [tfn_pkg::Q_W-1:0]      sx_in     [SS];
    logic [tfn_pkg::ROOT_W-1:0]   sroot_in  [SS];

    // remainder starts from the high part of the numerator, always below s
    assign drem_in[0] = tfn_pkg::REM_W'(n_in[tfn_pkg::N_W-1:tfn_pkg::Q_W]);
    assign dx_in[0]   = n_in[tfn_pkg::Q_W-1:0];
    assign ds_in[0]   = s_in;

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [tfn_pkg::REM_W-1:0] t;
        logic                      ge;

        if (k > 0)
        begin : g_link
            assign drem_in[k] = drem_reg[k-1];
            assign dx_in[k]   = dx_reg[k-1];
            assign ds_in[k]   = ds_reg[k-1];
        end

        assign t  = {drem_in[k][tfn_pkg::REM_W-2:0], dx_in[k][tfn_pkg::Q_W-1]};
        assign ge = t >= tfn_pkg::REM_W'(ds_in[k]);

        // numerator bits leave at the top, quotient bits enter at the bottom
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dx_reg[k] <= {dx_in[k][tfn_pkg::Q_W-2:0], ge};
            end
        end

        if (k < DS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[k] <= ge ? t - tfn_pkg::REM_W'(ds_in[k]) : t;
                    ds_reg[k]   <= ds_in[k];
                end
            end
        end
    end

    assign srem_in[0]  = '0;
    assign sx_in[0]    = dx_reg[DS-1];
    assign sroot_in[0] = '0;

    for (genvar j = 0; j < SS; j++)
    begin : g_sqrt
        logic [RT_W-1:0] rt;
        logic [RT_W-1:0] trial;
        logic            ge;

        if (j > 0)
        begin : g_link
            assign srem_in[j]  = srem_reg[j-1];
            assign sx_in[j]    = sx_reg[j-1];
            assign sroot_in[j] = sroot_reg[j-1];
        end

        assign rt    = {srem_in[j], sx_in[j][tfn_pkg::Q_W-1:tfn_pkg::Q_W-2]};
        assign trial = RT_W'({sroot_in[j][tfn_pkg::ROOT_W-2:0], 2'b01});
        assign ge    = rt >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sroot_reg[j] <= {sroot_in[j][tfn_pkg::ROOT_W-2:0], ge};
            end
        end

        if (j < SS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    srem_reg[j] <= tfn_pkg::SQ_REM_W'(ge ? rt - trial : rt);
                    sx_reg[j]   <= {sx_in[j][tfn_pkg::Q_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = sroot_reg[SS-1];

endmodule

`default_nettype wire

@@ sv/tfn_back.sv @@
// back pipeline: squares, scaled numerators, three lanes and final rounding
`default_nettype none

module tfn_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire tfn_pkg::front_item_t  in_item,
    output logic                       in_pop,
    output tfn_pkg::result_t           res,
    output logic                       res_valid,
    input  wire logic                  res_ready
);

    localparam int L = tfn_pkg::BACK_LAT;

    logic                             en;
    tfn_pkg::side_t                   side_reg [L];
    logic [tfn_pkg::SQ_W-1:0]         m2_reg  [3];
    logic [tfn_pkg::PP_W-1:0]         plo_reg [3];
    logic [tfn_pkg::PP_W-1:0]         phi_reg [3];
    logic [tfn_pkg::SUM_W-1:0]        s_reg;
    logic [tfn_pkg::SUM_W-1:0]        s3_reg;
    logic [tfn_pkg::N_W-1:0]          n_reg [3];
    logic [tfn_pkg::ROOT_W-1:0]       root [3];
    logic [tfn_pkg::ROOT_W:0]         rsum [3];
    logic [tfn_pkg::NORM_W-1:0]       rmag [3];
    logic signed [tfn_pkg::NORM_W-1:0] rval [3];
    tfn_pkg::result_t                 res_reg;
    tfn_pkg::side_t                   side_in;

    assign en     = !(side_reg[L-1].valid && !res_ready);
    assign in_pop = in_valid && en;

    always_comb
    begin
        side_in.valid = in_pop;
        side_in.neg   = in_item.neg;
        side_in.degen = in_item.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < L; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m2_reg[i]  <= tfn_pkg::SQ_W'(in_item.m[i]) * tfn_pkg::SQ_W'(in_item.m[i]);
                // numerator (2 * scale * m)^2 built from two 24 by 32 products
                plo_reg[i] <= tfn_pkg::PP_W'(m2_reg[i][tfn_pkg::MANT_W-1:0])
                              * tfn_pkg::PP_W'(tfn_pkg::NORM_C);
                phi_reg[i] <= tfn_pkg::PP_W'(m2_reg[i][tfn_pkg::SQ_W-1:tfn_pkg::MANT_W])
                              * tfn_pkg::PP_W'(tfn_pkg::NORM_C);
                n_reg[i]   <= tfn_pkg::N_W'(plo_reg[i])
                              + tfn_pkg::N_W'({phi_reg[i], tfn_pkg::MANT_W'(0)});
            end
            s_reg  <= tfn_pkg::SUM_W'(m2_reg[0]) + tfn_pkg::SUM_W'(m2_reg[1])
                      + tfn_pkg::SUM_W'(m2_reg[2]);
            s3_reg <= s_reg;
            res_reg.nx    <= rval[0];
            res_reg.ny    <= rval[1];
            res_reg.nz    <= rval[2];
            res_reg.degen <= side_reg[L-2].degen;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        tfn_lane u_lane (
            .clk  (clk),
            .en   (en),
            .n_in (n_reg[i]),
            .s_in (s3_reg),
            .root (root[i])
        );
    end

    // r = floor((isqrt(q) + 1) / 2), held to scale, then signed, or zero when degenerate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = {1'b0, root[i]} + (tfn_pkg::ROOT_W + 1)'(1);
            rmag[i] = (rsum[i][tfn_pkg::ROOT_W:1] > tfn_pkg::NORM_SCALE) ?
                      tfn_pkg::NORM_SCALE : rsum[i][tfn_pkg::ROOT_W:1];
            if (side_reg[L-2].degen)
            begin
                rval[i] = '0;
            end
            else if (side_reg[L-2].neg[i])
            begin
                rval[i] = -rmag[i];
            end
            else
            begin
                rval[i] = rmag[i];
            end
        end
    end

    assign res       = res_reg;
    assign res_valid = side_reg[L-1].valid;

endmodule

`default_nettype wire

@@ sv/triangle_face_normal_core.sv @@
// top level of the triangle face normal core
//
//   channel   direction  handshake        payload
//   triangle  in         push / full      a_x a_y a_z b_x b_y b_z c_x c_y c_z
//   normal    out        pop / empty      normal_x normal_y normal_z degenerate
//
// one triangle per cycle sustained while full stays low; every stage is a register stage, no unit is shared
// a request passes 7 front, 1 queue, 52 back and 1 output buffer register stages before
// its result shows, the first written at the accepting edge
// the back holds in place while its last stage holds a result and its output buffer is full,
// the front while its last item waits and the middle queue is full; each side stalls on its own
// reset clears only the valid and side bits, queue pointers and counts, nothing needs a clearing pass
`default_nettype none

module triangle_face_normal_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    a_x,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    a_y,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    a_z,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    b_x,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    b_y,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    b_z,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    c_x,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    c_y,
    input  wire logic signed [tfn_pkg::POS_W-1:0]    c_z,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic signed [tfn_pkg::NORM_W-1:0]        normal_x,
    output logic signed [tfn_pkg::NORM_W-1:0]        normal_y,
    output logic signed [tfn_pkg::NORM_W-1:0]        normal_z,
    output logic                                     degenerate
);

    tfn_pkg::front_item_t               f_item;
    logic                               f_valid;
    logic                               f_ready;
    tfn_pkg::front_item_t               q_item;
    logic                               q_valid;
    logic                               q_pop;
    tfn_pkg::result_t                   b_res;
    logic                               b_valid;
    logic                               b_ready;

    tfn_pkg::result_t                   oq_mem [tfn_pkg::OUTQ_DEPTH];
    logic [tfn_pkg::OUTQ_PTR_W-1:0]     oq_wr_reg;
    logic [tfn_pkg::OUTQ_PTR_W-1:0]     oq_rd_reg;
    logic [tfn_pkg::OUTQ_PTR_W:0]       oq_count_reg;
    logic [tfn_pkg::OUTQ_PTR_W:0]       oq_count_next;
    logic                               oq_push;
    logic                               oq_pop;

    tfn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    tfn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_ready  (f_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_pop   (q_pop)
    );

    tfn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_pop    (q_pop),
        .res       (b_res),
        .res_valid (b_valid),
        .res_ready (b_ready)
    );

    // output buffer: results wait here while the back keeps going
    assign b_ready = oq_count_reg != (tfn_pkg::OUTQ_PTR_W + 1)'(tfn_pkg::OUTQ_DEPTH);
    assign empty   = oq_count_reg == '0;
    assign oq_push = b_valid && b_ready;
    assign oq_pop  = pop && !empty;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + (tfn_pkg::OUTQ_PTR_W + 1)'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - (tfn_pkg::OUTQ_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + tfn_pkg::OUTQ_PTR_W'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + tfn_pkg::OUTQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= b_res;
        end
    end

    assign normal_x   = oq_mem[oq_rd_reg].nx;
    assign normal_y   = oq_mem[oq_rd_reg].ny;
    assign normal_z   = oq_mem[oq_rd_reg].nz;
    assign degenerate = oq_mem[oq_rd_reg].degen;

endmodule

`default_nettype wire

@@ sv/tfn_checker.sv @@
// port-level checks of the face normal core and their bind
`default_nettype none

`include "triangle_face_normal_core_assert.svh"

module tfn_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop,
    input  wire logic                              empty,
    input  wire logic signed [tfn_pkg::NORM_W-1:0] normal_x,
    input  wire logic signed [tfn_pkg::NORM_W-1:0] normal_y,
    input  wire logic signed [tfn_pkg::NORM_W-1:0] normal_z,
    input  wire logic                              degenerate
);

    // a flat triangle carries a zero normal
    `TFN_ASSERT_IMPLY(a_degen_zero, !empty && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate result with nonzero normal")

    // a real triangle always has one clearly nonzero component
    `TFN_ASSERT_IMPLY(a_normal_nonzero, !empty && !degenerate, normal_x != 0 || normal_y != 0 || normal_z != 0, "nondegenerate result with zero normal")

    // saturation keeps every component off the most negative code
    `TFN_ASSERT_IMPLY(a_normal_range, !empty, normal_x >= -$signed({1'b0, tfn_pkg::NORM_SCALE}) && normal_y >= -$signed({1'b0, tfn_pkg::NORM_SCALE}) && normal_z >= -$signed({1'b0, tfn_pkg::NORM_SCALE}), "normal component below negative scale")

    // an unread result stays put
    `TFN_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(degenerate), "waiting result changed")

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (.*);

`default_nettype wire

@@ sim/tb_triangle_face_normal_core.sv @@
// testbench of the triangle face normal core: random and directed triangles checked against a predictor
`default_nettype none

module tb_triangle_face_normal_core;

    localparam int NB = tfn_pkg::NORM_W;
    localparam longint unsigned UNIT = (64'd1 << (NB - 1)) - 1;

    typedef struct {
        logic signed [NB-1:0] nx;
        logic signed [NB-1:0] ny;
        logic signed [NB-1:0] nz;
        logic                 degen;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, degenerate;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [31:0] c_x = '0, c_y = '0, c_z = '0;
    logic signed [NB-1:0] normal_x, normal_y, normal_z;

    normal_t expected_normals[$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  hold_off = 0;

    triangle_face_normal_core uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .pop(pop), .empty(empty), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // largest r <= scale*m/sqrt(s) + 1/2, by exact squared compares
    function automatic longint unsigned rounded_share(longint unsigned m, longint unsigned s);
        longint unsigned lo, hi, mid, t;
        logic [127:0] rhs, lhs;
        lo = 0;
        hi = UNIT;
        rhs = 128'(2 * UNIT * m) * 128'(2 * UNIT * m);
        if (m == 0)
            return 0;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic normal_t face_normal(logic signed [31:0] p[9]);
        logic signed [32:0] ux, uy, uz, vx, vy, vz;
        logic signed [67:0] n[3];
        logic [67:0] mg[3];
        longint unsigned m[3], s, r;
        normal_t res;
        ux = 33'(p[3]) - 33'(p[0]);
        uy = 33'(p[4]) - 33'(p[1]);
        uz = 33'(p[5]) - 33'(p[2]);
        vx = 33'(p[6]) - 33'(p[0]);
        vy = 33'(p[7]) - 33'(p[1]);
        vz = 33'(p[8]) - 33'(p[2]);
        n[0] = 68'(uy) * 68'(vz) - 68'(uz) * 68'(vy);
        n[1] = 68'(uz) * 68'(vx) - 68'(ux) * 68'(vz);
        n[2] = 68'(ux) * 68'(vy) - 68'(uy) * 68'(vx);
        res = '{0, 0, 0, 1'b0};
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
            mg[i] = n[i] < 0 ? 68'(-n[i]) : 68'(n[i]);
        while ((mg[0] | mg[1] | mg[2]) >= 68'(1 << 24))
            for (int i = 0; i < 3; i++)
                mg[i] = mg[i] >> 1;
        for (int i = 0; i < 3; i++)
            m[i] = 64'(mg[i]);
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = rounded_share(m[0], s);
        res.nx = n[0] < 0 ? -NB'(r) : NB'(r);
        r = rounded_share(m[1], s);
        res.ny = n[1] < 0 ? -NB'(r) : NB'(r);
        r = rounded_share(m[2], s);
        res.nz = n[2] < 0 ? -NB'(r) : NB'(r);
        return res;
    endfunction

    task automatic send_triangle(logic signed [31:0] p[9]);
        while (!quiet && $urandom_range(99) < 38)
            @(negedge clk);
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} =
            {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
        push = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_normals.insert(expected_normals.size(), face_normal(p));
        @(negedge clk);
        push = 1'b0;
    endtask

    // receiver: random pop, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else
            pop <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_normals.size() == 0)
            begin
                $display("%0t: unexpected normal %0d %0d %0d %0b", $time,
                         normal_x, normal_y, normal_z, degenerate);
                errors++;
            end
            else
            begin
                e = expected_normals.pop_front();
                if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz
                    || degenerate !== e.degen)
                begin
                    $display("%0t: expected %0d %0d %0d %0b actual %0d %0d %0d %0b", $time,
                             e.nx, e.ny, e.nz, e.degen,
                             normal_x, normal_y, normal_z, degenerate);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(2000))) - 1000;
            2: return $signed($urandom) >>> $urandom_range(31);
            default: return $signed(32'($urandom_range(65536 * 8))) - 65536 * 4;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] p[9];
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        p = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
        send_triangle(p);
        p = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
        send_triangle(p);
        p = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
        send_triangle(p);
        p = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
        send_triangle(p);
        p = '{-1, -1, -1, 0, 0, 0, -1, 0, -1};
        send_triangle(p);
    endtask

    task automatic test_degenerate();
        logic signed [31:0] p[9];
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_triangle(p);
        p = '{5, 6, 7, 5, 6, 7, 100, -3, 9};
        send_triangle(p);
        p = '{0, 0, 0, 1000, 2000, 3000, 2000, 4000, 6000};
        send_triangle(p);
        p = '{32'sh7fffffff, 1, 2, 32'sh7fffffff, 1, 2, 32'sh7fffffff, 1, 2};
        send_triangle(p);
    endtask

    task automatic test_small_cross();
        logic signed [31:0] p[9];
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_triangle(p);
        p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        send_triangle(p);
        p = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
        send_triangle(p);
        p = '{10, 20, 30, 13, 24, 30, 10, 20, 35};
        send_triangle(p);
        p = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
        send_triangle(p);
        p = '{-3, 4, -5, 2, -7, 1, 9, 0, -2};
        send_triangle(p);
    endtask

    task automatic test_random(int count);
        logic signed [31:0] p[9];
        for (int k = 0; k < count; k++)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord();
            // now and then a collinear or repeated corner
            if ($urandom_range(19) == 0)
                for (int i = 0; i < 3; i++)
                    p[6 + i] = p[3 + i];
            quiet = (k >= count / 2 && k < count / 2 + 150);
            send_triangle(p);
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        logic signed [31:0] p[9];
        @(negedge clk);
        hold_off <= 200;
        for (int k = 0; k < 80; k++)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord();
            send_triangle(p);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_degenerate();
        test_small_cross();
        test_backpressure();
        test_random(1100);
        while (expected_normals.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
